// ----- rtl/core/utf8d_pkg.sv -----
package utf8d_pkg;

	// sticky error codes
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LEAD  = 2'd1,
		ERR_CONT  = 2'd2,
		ERR_TRUNC = 2'd3
	} err_t;

	// byte masks and continuation tag
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] TAG_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// one input item
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] capacity;
	} byte_item_t;

	// one result item
	typedef struct packed {
		logic        char_valid;
		logic [15:0] code_unit;
		logic        string_done;
		logic [15:0] char_count;
		logic [1:0]  error_code;
	} result_item_t;

	// sequence state carried from byte to byte
	typedef struct packed {
		logic [1:0]  pending;
		logic [11:0] partial;
		err_t        err;
	} seq_state_t;

endpackage

// ----- rtl/core/utf8d_step.sv -----
module utf8d_step #(
	parameter int COUNT_BITS = 16
) (
	input  utf8d_pkg::byte_item_t   item,
	input  utf8d_pkg::seq_state_t   state_cur,
	input  logic [COUNT_BITS-1:0]   room_cur,
	input  logic [COUNT_BITS-1:0]   count_cur,
	output utf8d_pkg::seq_state_t   state_nxt,
	output logic [COUNT_BITS-1:0]   room_nxt,
	output logic [COUNT_BITS-1:0]   count_nxt,
	output utf8d_pkg::result_item_t result
);

	logic [COUNT_BITS-1:0] cap_clip;

	// capacity clipped to the count range
	generate
		if (COUNT_BITS >= 16) begin : g_cap_wide
			assign cap_clip = COUNT_BITS'(item.capacity);
		end else begin : g_cap_narrow
			assign cap_clip = (|item.capacity[15:COUNT_BITS]) ? '1 :
				item.capacity[COUNT_BITS-1:0];
		end
	endgenerate

	// decode one byte against the running sequence state
	always_comb begin
		utf8d_pkg::seq_state_t st;
		logic [COUNT_BITS-1:0] room;
		logic [COUNT_BITS-1:0] cnt;
		logic                  done;
		logic [15:0]           value;
		logic                  valid;
		logic [7:0]            b;
		b     = item.data_byte;
		st    = item.first_byte ? '0 : state_cur;
		room  = item.first_byte ? cap_clip : room_cur;
		cnt   = item.first_byte ? '0 : count_cur;
		done  = 1'b0;
		value = '0;
		valid = 1'b0;

		if (st.err == utf8d_pkg::ERR_NONE) begin
			if (st.pending == 2'd0) begin
				// lead byte
				case (b[7:4]) inside
					[4'h0:4'h7]: begin
						done  = 1'b1;
						value = {8'h00, b};
					end
					4'hC, 4'hD: begin
						st.pending = 2'd1;
						st.partial = {4'h0, b & utf8d_pkg::LEAD2_MASK};
					end
					4'hE: begin
						st.pending = 2'd2;
						st.partial = {4'h0, b & utf8d_pkg::LEAD3_MASK};
					end
					default: begin
						st.err = utf8d_pkg::ERR_LEAD;
					end
				endcase
			end else begin
				// continuation byte
				if (item.last_byte && st.pending == 2'd2) begin
					st.err = utf8d_pkg::ERR_TRUNC;
				end else if ((b & utf8d_pkg::TAG_MASK) != utf8d_pkg::CONT_TAG) begin
					st.err = utf8d_pkg::ERR_CONT;
				end else begin
					value      = {st.partial[9:0], b[5:0]};
					st.partial = {st.partial[5:0], b[5:0]};
					st.pending = st.pending - 2'd1;
					done       = (st.pending == 2'd0);
				end
				if (st.err != utf8d_pkg::ERR_NONE) begin
					st.pending = 2'd0;
					st.partial = '0;
				end
			end

			// sequence cut off by the end of the string
			if (item.last_byte && st.err == utf8d_pkg::ERR_NONE && st.pending != 2'd0) begin
				st.err = utf8d_pkg::ERR_TRUNC;
			end

			// emit while room remains
			if (done) begin
				st.partial = '0;
				if (room != '0) begin
					room  = room - COUNT_BITS'(1);
					if (cnt != '1) begin
						cnt = cnt + COUNT_BITS'(1);
					end
					valid = 1'b1;
				end
			end
		end

		if (item.last_byte) begin
			st.pending = 2'd0;
			st.partial = '0;
		end

		state_nxt          = st;
		room_nxt           = room;
		count_nxt          = cnt;
		result.char_valid  = valid;
		result.code_unit   = valid ? value : 16'h0000;
		result.string_done = item.last_byte;
		result.char_count  = 16'(cnt);
		result.error_code  = st.err;
	end

endmodule

// ----- rtl/core/utf8_to_ucs2_decoder.sv -----
// UTF-8 to 16-bit code unit decoder, one byte per item.
// Input channel byte_valid/byte_ready/byte_item carries one raw byte with
// first and last flags; capacity is sampled on the first byte of a string.
// Output channel result_valid/result_ready/result_item gives exactly one
// result per byte: a code unit when a character completes and fits, the
// running count, the sticky error and a done flag on the last byte.
// Each byte is held in an input register, decoded combinationally against the
// sequence state and written to the result register, which drives
// result_valid; one byte per cycle sustained while the receiver keeps
// result_ready high.
// When the receiver stalls the result register holds, the input register
// fills, and byte_ready drops until the result is taken.
// Reset clears both registers' valid flags and the decode state (no
// sequence pending, zero room, zero count, no error).
module utf8_to_ucs2_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_ready,
	input  utf8d_pkg::byte_item_t    byte_item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output utf8d_pkg::result_item_t  result_item
);

	utf8d_pkg::byte_item_t   item_s1;
	logic                    vld_s1;
	utf8d_pkg::result_item_t res_s2;
	logic                    vld_s2;
	utf8d_pkg::seq_state_t   state_q;
	logic [COUNT_BITS-1:0]   room_q;
	logic [COUNT_BITS-1:0]   count_q;
	utf8d_pkg::seq_state_t   state_nxt;
	logic [COUNT_BITS-1:0]   room_nxt;
	logic [COUNT_BITS-1:0]   count_nxt;
	utf8d_pkg::result_item_t res_nxt;
	logic                    advance;

	// handshake
	assign advance    = vld_s1 && (!vld_s2 || result_ready);
	assign byte_ready = !vld_s1 || advance;

	// decode logic
	utf8d_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.item      (item_s1),
		.state_cur (state_q),
		.room_cur  (room_q),
		.count_cur (count_q),
		.state_nxt (state_nxt),
		.room_nxt  (room_nxt),
		.count_nxt (count_nxt),
		.result    (res_nxt)
	);

	// valid flags and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			state_q <= '0;
			room_q  <= '0;
			count_q <= '0;
		end else begin
			if (byte_ready) begin
				vld_s1 <= byte_valid;
			end
			if (advance) begin
				vld_s2  <= 1'b1;
				state_q <= state_nxt;
				room_q  <= room_nxt;
				count_q <= count_nxt;
			end else if (result_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = vld_s2;
	assign result_item  = res_s2;

	// a decoded item always lands in the result register
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2)
		else $error("result register not loaded after advance");

	// an emitted character never carries an error
	a_char_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.char_valid) |-> (res_s2.error_code == utf8d_pkg::ERR_NONE))
		else $error("character emitted with error set");

	// at most two continuation bytes are ever pending
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending != 2'd3)
		else $error("pending count out of range");

	// an error leaves no partial sequence behind
	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.err != utf8d_pkg::ERR_NONE) |->
			(state_q.pending == 2'd0 && state_q.partial == 12'h000))
		else $error("partial sequence kept after error");

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 700;

	// expected code units and the decoder state that produces them
	class unit_scoreboard;
		utf8d_pkg::result_item_t expected_units[$];
		int fail_count;
		logic [1:0] pending;
		logic [11:0] partial;
		logic [15:0] room;
		logic [15:0] count;
		utf8d_pkg::err_t err;

		function new();
			pending = '0;
			partial = '0;
			room = '0;
			count = '0;
			err = utf8d_pkg::ERR_NONE;
			fail_count = 0;
		endfunction

		// decode one accepted byte and queue the result it gives
		function void note_byte(utf8d_pkg::byte_item_t it);
			utf8d_pkg::result_item_t res;
			logic [15:0] acc;
			logic [15:0] value;
			logic done;
			res = '0;
			value = '0;
			done = 1'b0;
			if (it.first_byte) begin
				pending = '0;
				partial = '0;
				room = it.capacity;
				count = '0;
				err = utf8d_pkg::ERR_NONE;
			end
			if (err == utf8d_pkg::ERR_NONE) begin
				if (pending == 2'd0) begin
					// lead byte
					case (it.data_byte[7:4])
						4'hC, 4'hD: begin
							pending = 2'd1;
							partial = {4'h0, it.data_byte & utf8d_pkg::LEAD2_MASK};
						end
						4'hE: begin
							pending = 2'd2;
							partial = {4'h0, it.data_byte & utf8d_pkg::LEAD3_MASK};
						end
						default: begin
							if (!it.data_byte[7]) begin
								done = 1'b1;
								value = {8'h00, it.data_byte};
							end else begin
								err = utf8d_pkg::ERR_LEAD;
							end
						end
					endcase
				end else begin
					// continuation byte; a cut-off three-byte sequence wins
					if (it.last_byte && pending == 2'd2) begin
						err = utf8d_pkg::ERR_TRUNC;
					end else if ((it.data_byte & utf8d_pkg::TAG_MASK) !=
						utf8d_pkg::CONT_TAG) begin
						err = utf8d_pkg::ERR_CONT;
					end else begin
						acc = ({4'h0, partial} << 6) |
							{8'h00, it.data_byte & utf8d_pkg::CONT_MASK};
						pending = pending - 2'd1;
						partial = acc[11:0];
						if (pending == 2'd0) begin
							done = 1'b1;
							value = acc;
						end
					end
					if (err != utf8d_pkg::ERR_NONE) begin
						pending = '0;
						partial = '0;
					end
				end
				if (it.last_byte && err == utf8d_pkg::ERR_NONE && pending != 2'd0)
					err = utf8d_pkg::ERR_TRUNC;
				// emit only while room remains
				if (done) begin
					partial = '0;
					if (room != 16'd0) begin
						room = room - 16'd1;
						if (count != 16'hFFFF)
							count = count + 16'd1;
						res.char_valid = 1'b1;
						res.code_unit = value;
					end
				end
			end
			if (it.last_byte) begin
				pending = '0;
				partial = '0;
			end
			res.string_done = it.last_byte;
			res.char_count = count;
			res.error_code = err;
			expected_units.push_back(res);
		endfunction

		// compare one taken result with the oldest expectation
		function void check_result(utf8d_pkg::result_item_t got);
			utf8d_pkg::result_item_t want;
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				fail_count++;
				return;
			end
			want = expected_units.pop_front();
			if (got.char_valid !== want.char_valid) begin
				$display("%0t: char_valid expected %0d actual %0d", $time,
					want.char_valid, got.char_valid);
				fail_count++;
			end
			if (got.code_unit !== want.code_unit) begin
				$display("%0t: code_unit expected %h actual %h", $time,
					want.code_unit, got.code_unit);
				fail_count++;
			end
			if (got.string_done !== want.string_done) begin
				$display("%0t: string_done expected %0d actual %0d", $time,
					want.string_done, got.string_done);
				fail_count++;
			end
			if (got.char_count !== want.char_count) begin
				$display("%0t: char_count expected %0d actual %0d", $time,
					want.char_count, got.char_count);
				fail_count++;
			end
			if (got.error_code !== want.error_code) begin
				$display("%0t: error_code expected %0d actual %0d", $time,
					want.error_code, got.error_code);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	utf8d_pkg::byte_item_t byte_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	utf8d_pkg::result_item_t result_item;

	unit_scoreboard sb = new();
	logic [7:0] utf8_text[$];
	int items_sent = 0;
	int results_taken = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit steady = 1'b0;

	utf8_to_ucs2_decoder #(
		.COUNT_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// take results
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_result(result_item);
			results_taken++;
		end
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int stall_left;
		int mode;
		int mode_cycles;
		int phase;
		bit held;
		stall_left = 0;
		mode = 0;
		mode_cycles = 0;
		phase = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_taken >= 200) begin
				held = 1'b1;
				stall_left = $urandom_range(300, 400);
			end
			if (mode_cycles == 0) begin
				mode = $urandom_range(0, 3);
				mode_cycles = $urandom_range(32, 200);
			end else begin
				mode_cycles--;
			end
			phase = (phase + 1) % 7;
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= $urandom_range(0, 1);
					2: result_ready <= $urandom_range(0, 3) != 0;
					default: result_ready <= phase < 3;
				endcase
			end
		end
	end

	// offer one item and hold it until taken, then maybe pause between bursts
	task send_byte(input utf8d_pkg::byte_item_t it);
		byte_valid <= 1'b1;
		byte_item <= it;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		sb.note_byte(it);
		items_sent++;
		if (!steady) begin
			if (burst_left == 0) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	// send the bytes in utf8_text as one string
	task send_text(input bit restart, input logic [15:0] cap);
		utf8d_pkg::byte_item_t it;
		foreach (utf8_text[i]) begin
			it.data_byte = utf8_text[i];
			it.first_byte = restart && i == 0;
			it.last_byte = i == utf8_text.size() - 1;
			it.capacity = it.first_byte ? cap : 16'($urandom);
			send_byte(it);
		end
	endtask

	// append one well-formed character of one, two or three bytes
	function void add_char();
		case ($urandom_range(0, 2))
			0: utf8_text.push_back(8'($urandom_range(0, 127)));
			1: begin
				utf8_text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
				utf8_text.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
			default: begin
				utf8_text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
				utf8_text.push_back(8'h80 | 8'($urandom_range(0, 63)));
				utf8_text.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		endcase
	endfunction

	// stimulus
	initial begin
		int kind;
		int nchars;
		int pos;
		int directed_items;
		logic [15:0] cap;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any first byte run with zero room
		utf8_text = '{8'h41};
		send_text(1'b0, 16'hFFFF);
		utf8_text = '{8'hC3};
		send_text(1'b0, 16'hFFFF);
		// every sequence length, extremes of value, full capacity
		utf8_text = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF, 8'h7F};
		send_text(1'b1, 16'hFFFF);
		// zero capacity: decoded but dropped
		utf8_text = '{8'hC3, 8'hA9};
		send_text(1'b1, 16'h0000);
		// capacity runs out, then bytes after last without a new first
		utf8_text = '{8'h41, 8'h42};
		send_text(1'b1, 16'd2);
		utf8_text = '{8'h43};
		send_text(1'b0, 16'd0);
		// bad lead bytes
		utf8_text = '{8'h80};
		send_text(1'b1, 16'd5);
		utf8_text = '{8'hF0, 8'h41};
		send_text(1'b1, 16'd5);
		// bad continuation
		utf8_text = '{8'hC3, 8'h41};
		send_text(1'b1, 16'd5);
		// three-byte sequence cut at its second byte, bad continuation there too
		utf8_text = '{8'hE2, 8'h41};
		send_text(1'b1, 16'd5);
		// lead byte on the last byte
		utf8_text = '{8'hC3};
		send_text(1'b1, 16'd5);
		directed_items = items_sent;

		// random strings: mostly well formed, some broken, some noise
		while (items_sent < directed_items + RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				steady = $urandom_range(0, 2) == 0;
			utf8_text.delete();
			kind = $urandom_range(0, 9);
			nchars = $urandom_range(1, 10);
			if (kind == 8) begin
				repeat (nchars) utf8_text.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat (nchars) add_char();
			end
			if (kind == 7) begin
				pos = $urandom_range(0, utf8_text.size() - 1);
				if ($urandom_range(0, 1))
					utf8_text = utf8_text[0:pos];
				else
					utf8_text[pos] = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 4) == 0)
				cap = 16'($urandom);
			else
				cap = 16'($urandom_range(0, nchars + 1));
			send_text(kind != 9, cap);
		end
		byte_valid <= 1'b0;

		// drain
		while (sb.expected_units.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fail_count == 0 && sb.expected_units.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_step.sv
rtl/core/utf8_to_ucs2_decoder.sv
sim/testbench.sv
